// ===== sv/ledsr_pkg.sv =====
// Shared constants, codes and types for the LED driver serial refresh core.
package ledsr_pkg;

    // Buffer geometry
    localparam int          DIGITS     = 16;
    localparam int          ADDR_W     = 4;
    localparam int          CNT_W      = 5;
    localparam logic [CNT_W-1:0] DIGITS_CNT = CNT_W'(DIGITS);

    // Command bytes
    localparam logic [7:0]  CMD_DATA   = 8'h40;
    localparam logic [7:0]  CMD_ADDR   = 8'hC0;
    localparam logic [7:0]  CTRL_RESET = 8'h88;

    // Item selector codes
    localparam logic [1:0]  FUNC_TICK    = 2'd0;
    localparam logic [1:0]  FUNC_WRITE   = 2'd1;
    localparam logic [1:0]  FUNC_REFRESH = 2'd2;

    // Phase kinds of the waveform sequencer
    localparam logic [1:0]  KIND_IDLE  = 2'd0;
    localparam logic [1:0]  KIND_START = 2'd1;
    localparam logic [1:0]  KIND_BYTE  = 2'd2;
    localparam logic [1:0]  KIND_STOP  = 2'd3;

    // Transaction numbers within a frame
    localparam logic [1:0]  TX_DATA = 2'd0;
    localparam logic [1:0]  TX_ADDR = 2'd1;
    localparam logic [1:0]  TX_CTRL = 2'd2;

    // Buffer write request from the sequencer
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } buf_wr_t;

endpackage

// ===== sv/led_driver_serial_refresh_core.sv =====
// Top level: two-wire LED driver refresh sequencer with stream in/out channels.
// One item is taken per clock cycle and its result appears on the master side
// the next cycle; the only stall is back-pressure from m_tready. Each tick
// (func 0) advances the SCL/SDA waveform by one phase: start is 3 ticks, each
// byte 17 ticks (two per bit plus one trailing phase), stop 3 ticks, so a full
// frame with 16 digits takes 3*6 + 19*17 = 341 ticks. A refresh request (func 2)
// arms a frame when idle; buffer writes (func 1) are stored at once. The 16-byte
// display buffer sits in a registered-read memory that is read ahead at the
// next byte position; valid bits cleared at reset make it read as zero, so no
// clearing pass is needed and items are taken right after reset.
module led_driver_serial_refresh_core (
    input  logic        aclk,
    input  logic        aresetn,
    // input item channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [3:0] digit_index, [11:4] digit_data, [15:12] zero
    input  logic [1:0]  s_tuser,   // [1:0] func
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] scl, [1] sda, [2] busy_res, [7:3] zero
    output logic        m_tlast,   // frame_done
    // display control register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    logic                          s_fire;
    logic [1:0]                    func;
    logic [ledsr_pkg::ADDR_W-1:0]  digit_index;
    logic [7:0]                    digit_data;

    logic [7:0]                    ctrl_reg;
    logic [1:0]                    kind_reg,    kind_next;
    logic [1:0]                    step_reg,    step_next;
    logic [3:0]                    bit_cnt_reg, bit_cnt_next;
    logic [1:0]                    tx_idx_reg,  tx_idx_next;
    logic [ledsr_pkg::CNT_W-1:0]   byte_cnt_reg, byte_cnt_next;
    logic [7:0]                    shift_reg,   shift_next;
    logic                          scl_reg,     scl_next;
    logic                          sda_reg,     sda_next;
    logic                          done;

    logic                          m_valid_reg;
    logic [2:0]                    m_data_reg;
    logic                          m_last_reg;

    ledsr_pkg::buf_wr_t            buf_wr;
    logic [7:0]                    buf_rd_data;

    assign func        = s_tuser;
    assign digit_index = s_tdata[3:0];
    assign digit_data  = s_tdata[11:4];

    assign s_tready  = aresetn && (!m_valid_reg || m_tready);
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = aresetn;

    // read ahead at the byte position the sequencer holds next cycle
    ledsr_dispbuf u_dispbuf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (buf_wr),
        .rd_addr (byte_cnt_next[ledsr_pkg::ADDR_W-1:0]),
        .rd_data (buf_rd_data)
    );

    always_comb begin
        kind_next     = kind_reg;
        step_next     = step_reg;
        bit_cnt_next  = bit_cnt_reg;
        tx_idx_next   = tx_idx_reg;
        byte_cnt_next = byte_cnt_reg;
        shift_next    = shift_reg;
        scl_next      = scl_reg;
        sda_next      = sda_reg;
        done          = 1'b0;
        buf_wr.en     = 1'b0;
        buf_wr.addr   = digit_index;
        buf_wr.data   = digit_data;

        if (s_fire) begin
            case (func)
                ledsr_pkg::FUNC_TICK: begin
                    unique case (kind_reg)
                        ledsr_pkg::KIND_START: begin
                            if (step_reg == 2'd0) begin
                                scl_next  = 1'b1;
                                sda_next  = 1'b1;
                                step_next = 2'd1;
                            end else if (step_reg == 2'd1) begin
                                sda_next  = 1'b0;
                                step_next = 2'd2;
                            end else begin
                                scl_next      = 1'b0;
                                kind_next     = ledsr_pkg::KIND_BYTE;
                                step_next     = 2'd0;
                                bit_cnt_next  = 4'd0;
                                byte_cnt_next = '0;
                                if (tx_idx_reg == ledsr_pkg::TX_DATA) begin
                                    shift_next = ledsr_pkg::CMD_DATA;
                                end else if (tx_idx_reg == ledsr_pkg::TX_ADDR) begin
                                    shift_next = ledsr_pkg::CMD_ADDR;
                                end else begin
                                    shift_next = ctrl_reg;
                                end
                            end
                        end
                        ledsr_pkg::KIND_BYTE: begin
                            if (bit_cnt_reg < 4'd8) begin
                                if (step_reg == 2'd0) begin
                                    sda_next  = shift_reg[0];
                                    scl_next  = 1'b1;
                                    step_next = 2'd1;
                                end else begin
                                    scl_next     = 1'b0;
                                    shift_next   = {1'b0, shift_reg[7:1]};
                                    bit_cnt_next = bit_cnt_reg + 4'd1;
                                    step_next    = 2'd0;
                                end
                            end else if (tx_idx_reg == ledsr_pkg::TX_ADDR
                                         && byte_cnt_reg < ledsr_pkg::DIGITS_CNT) begin
                                // load the next digit from the prefetched buffer word
                                shift_next    = buf_rd_data;
                                byte_cnt_next = byte_cnt_reg + 1'b1;
                                bit_cnt_next  = 4'd0;
                                step_next     = 2'd0;
                            end else begin
                                kind_next = ledsr_pkg::KIND_STOP;
                                step_next = 2'd0;
                            end
                        end
                        ledsr_pkg::KIND_STOP: begin
                            if (step_reg == 2'd0) begin
                                sda_next  = 1'b0;
                                scl_next  = 1'b1;
                                step_next = 2'd1;
                            end else if (step_reg == 2'd1) begin
                                sda_next  = 1'b1;
                                step_next = 2'd2;
                            end else begin
                                scl_next  = 1'b0;
                                step_next = 2'd0;
                                if (tx_idx_reg < ledsr_pkg::TX_CTRL) begin
                                    tx_idx_next = tx_idx_reg + 2'd1;
                                    kind_next   = ledsr_pkg::KIND_START;
                                end else begin
                                    tx_idx_next = ledsr_pkg::TX_DATA;
                                    kind_next   = ledsr_pkg::KIND_IDLE;
                                    done        = 1'b1;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                ledsr_pkg::FUNC_WRITE: begin
                    buf_wr.en = ({1'b0, digit_index} < ledsr_pkg::DIGITS_CNT);
                end
                ledsr_pkg::FUNC_REFRESH: begin
                    if (kind_reg == ledsr_pkg::KIND_IDLE) begin
                        kind_next     = ledsr_pkg::KIND_START;
                        step_next     = 2'd0;
                        bit_cnt_next  = 4'd0;
                        tx_idx_next   = ledsr_pkg::TX_DATA;
                        byte_cnt_next = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg     <= ledsr_pkg::CTRL_RESET;
            kind_reg     <= ledsr_pkg::KIND_IDLE;
            step_reg     <= 2'd0;
            bit_cnt_reg  <= 4'd0;
            tx_idx_reg   <= ledsr_pkg::TX_DATA;
            byte_cnt_reg <= '0;
            shift_reg    <= 8'h00;
            scl_reg      <= 1'b1;
            sda_reg      <= 1'b1;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                ctrl_reg <= cfg_data;
            end
            kind_reg     <= kind_next;
            step_reg     <= step_next;
            bit_cnt_reg  <= bit_cnt_next;
            tx_idx_reg   <= tx_idx_next;
            byte_cnt_reg <= byte_cnt_next;
            shift_reg    <= shift_next;
            scl_reg      <= scl_next;
            sda_reg      <= sda_next;
            if (s_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_data_reg <= {kind_next != ledsr_pkg::KIND_IDLE, sda_next, scl_next};
            m_last_reg <= done;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b00000, m_data_reg};
    assign m_tlast  = m_last_reg;

    // the frame-complete flag never comes with busy set
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> !m_tdata[2])
        else $error("frame_done reported while busy");

    // an idle sequencer is always back at the first transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        kind_reg == ledsr_pkg::KIND_IDLE |-> tx_idx_reg == ledsr_pkg::TX_DATA)
        else $error("idle with a transaction pending");

    // phase step never reaches its unused code
    assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg != 2'd3)
        else $error("phase step out of range");

    // bit counter stays within one byte plus the trailing phase
    assert property (@(posedge aclk) disable iff (!aresetn)
        kind_reg == ledsr_pkg::KIND_BYTE |-> bit_cnt_reg <= 4'd8)
        else $error("bit counter overrun");

    // an accepted transaction always yields a result the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> m_valid_reg)
        else $error("result lost");

endmodule

// ===== sv/ledsr_dispbuf.sv =====
// Display buffer memory with valid bits and same-cycle write forwarding.
module ledsr_dispbuf (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  ledsr_pkg::buf_wr_t          wr,
    input  logic [ledsr_pkg::ADDR_W-1:0] rd_addr,
    output logic [7:0]                  rd_data
);

    logic [7:0]            mem [ledsr_pkg::DIGITS];
    logic [ledsr_pkg::DIGITS-1:0] valid_reg;
    logic [7:0]            mem_q_reg;
    logic                  valid_q_reg;
    logic                  fwd_sel_reg;
    logic [7:0]            fwd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        mem_q_reg    <= mem[rd_addr];
        fwd_data_reg <= wr.data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            valid_q_reg <= 1'b0;
            fwd_sel_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                valid_reg[wr.addr] <= 1'b1;
            end
            valid_q_reg <= valid_reg[rd_addr];
            // bypass a write that lands on the entry being read
            fwd_sel_reg <= wr.en && (wr.addr == rd_addr);
        end
    end

    // unwritten entries read as the cleared value
    assign rd_data = fwd_sel_reg ? fwd_data_reg : (valid_q_reg ? mem_q_reg : 8'h00);

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the LED driver serial refresh core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] FUNC_NOP = 2'd3;
    localparam int PHASE_ITEMS = 270;

    typedef struct {
        logic [1:0] func;
        logic [3:0] idx;
        logic [7:0] data;
    } led_item_t;

    typedef struct {
        logic scl;
        logic sda;
        logic busy;
        logic done;
    } line_state_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;   // [3:0] digit_index, [11:4] digit_data, [15:12] zero
    logic [1:0]  s_tuser   = '0;   // [1:0] func
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;          // [0] scl, [1] sda, [2] busy_res, [7:3] zero
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data  = '0;

    led_driver_serial_refresh_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Line-level model of the sequencer
    logic [7:0] seg_buf [ledsr_pkg::DIGITS];
    logic [7:0] ctrl_byte;
    logic [1:0] seq_kind;
    logic [1:0] seq_step;
    logic [1:0] tx_num;
    logic [3:0] bit_cnt;
    logic [4:0] byte_cnt;
    logic [7:0] shifter;
    logic       scl_lvl;
    logic       sda_lvl;

    led_item_t   pend_q[$];
    line_state_t levels_q[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int items_sent     = 0;
    int results_seen   = 0;
    int frames_seen    = 0;
    int errors         = 0;

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Move the waveform on by one phase; return 1 when the final stop completes.
    function automatic logic advance_phase();
        logic done;
        done = 1'b0;
        case (seq_kind)
            ledsr_pkg::KIND_START: begin
                if (seq_step == 2'd0) begin
                    scl_lvl  = 1'b1;
                    sda_lvl  = 1'b1;
                    seq_step = 2'd1;
                end else if (seq_step == 2'd1) begin
                    sda_lvl  = 1'b0;
                    seq_step = 2'd2;
                end else begin
                    scl_lvl  = 1'b0;
                    seq_kind = ledsr_pkg::KIND_BYTE;
                    seq_step = 2'd0;
                    bit_cnt  = '0;
                    byte_cnt = '0;
                    if (tx_num == ledsr_pkg::TX_DATA)
                        shifter = ledsr_pkg::CMD_DATA;
                    else if (tx_num == ledsr_pkg::TX_ADDR)
                        shifter = ledsr_pkg::CMD_ADDR;
                    else
                        shifter = ctrl_byte;
                end
            end
            ledsr_pkg::KIND_BYTE: begin
                if (bit_cnt < 4'd8) begin
                    if (seq_step == 2'd0) begin
                        sda_lvl  = shifter[0];
                        scl_lvl  = 1'b1;
                        seq_step = 2'd1;
                    end else begin
                        scl_lvl  = 1'b0;
                        shifter  = shifter >> 1;
                        bit_cnt  = bit_cnt + 4'd1;
                        seq_step = 2'd0;
                    end
                end else if (tx_num == ledsr_pkg::TX_ADDR
                             && byte_cnt < ledsr_pkg::DIGITS_CNT) begin
                    // load the next digit late so writes during the frame go out
                    shifter  = seg_buf[byte_cnt[3:0]];
                    byte_cnt = byte_cnt + 5'd1;
                    bit_cnt  = '0;
                    seq_step = 2'd0;
                end else begin
                    seq_kind = ledsr_pkg::KIND_STOP;
                    seq_step = 2'd0;
                end
            end
            ledsr_pkg::KIND_STOP: begin
                if (seq_step == 2'd0) begin
                    sda_lvl  = 1'b0;
                    scl_lvl  = 1'b1;
                    seq_step = 2'd1;
                end else if (seq_step == 2'd1) begin
                    sda_lvl  = 1'b1;
                    seq_step = 2'd2;
                end else begin
                    scl_lvl  = 1'b0;
                    seq_step = 2'd0;
                    if (tx_num != ledsr_pkg::TX_CTRL) begin
                        tx_num   = tx_num + 2'd1;
                        seq_kind = ledsr_pkg::KIND_START;
                    end else begin
                        tx_num   = ledsr_pkg::TX_DATA;
                        seq_kind = ledsr_pkg::KIND_IDLE;
                        done     = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        return done;
    endfunction

    function automatic line_state_t predict_levels(led_item_t it);
        line_state_t r;
        r.done = 1'b0;
        case (it.func)
            ledsr_pkg::FUNC_TICK: r.done = advance_phase();
            ledsr_pkg::FUNC_WRITE: begin
                if (int'(it.idx) < ledsr_pkg::DIGITS)
                    seg_buf[it.idx] = it.data;
            end
            ledsr_pkg::FUNC_REFRESH: begin
                // arm only when idle; a request during a frame is dropped
                if (seq_kind == ledsr_pkg::KIND_IDLE) begin
                    seq_kind = ledsr_pkg::KIND_START;
                    seq_step = 2'd0;
                    bit_cnt  = '0;
                    tx_num   = ledsr_pkg::TX_DATA;
                    byte_cnt = '0;
                end
            end
            default: ;
        endcase
        r.scl  = scl_lvl;
        r.sda  = sda_lvl;
        r.busy = (seq_kind != ledsr_pkg::KIND_IDLE);
        return r;
    endfunction

    task automatic report_mismatch(string what);
        errors++;
        $display("[%0t] result %0d: %s", $realtime, results_seen, what);
    endtask

    task automatic check_field(string name, logic got, logic want);
        if (got !== want)
            report_mismatch($sformatf("%s is %b, expected %b", name, got, want));
    endtask

    task automatic add_item(logic [1:0] func, logic [3:0] idx, logic [7:0] data);
        led_item_t it;
        it.func = func;
        it.idx  = idx;
        it.data = data;
        pend_q.push_back(it);
    endtask

    task automatic wait_drained();
        while (pend_q.size() != 0 || s_tvalid || levels_q.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_ctrl(logic [7:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        ctrl_byte = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Driver: present the head of the pending queue, hold it until taken.
    always @(negedge aclk) begin
        if (aresetn && !s_tvalid && pend_q.size() != 0 &&
            $urandom_range(99) >= send_idle_pct) begin
            s_tvalid <= 1'b1;
            s_tuser  <= pend_q[0].func;
            s_tdata  <= {4'd0, pend_q[0].data, pend_q[0].idx};
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            levels_q.push_back(predict_levels(pend_q.pop_front()));
            items_sent++;
            s_tvalid <= 1'b0;
        end
    end

    // Monitor: random back-pressure, compare each result transaction in order.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        line_state_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (levels_q.size() == 0) begin
                report_mismatch("result transaction with nothing expected");
            end else begin
                want = levels_q.pop_front();
                check_field("scl", m_tdata[0], want.scl);
                check_field("sda", m_tdata[1], want.sda);
                check_field("busy", m_tdata[2], want.busy);
                check_field("frame_done", m_tlast, want.done);
                if (want.done)
                    frames_seen++;
            end
        end
    end

    initial begin
        int idle_tab[4];
        int stall_tab[4];
        int r;
        led_item_t it;
        idle_tab  = '{0, 84, 0, 30};
        stall_tab = '{0, 0, 84, 30};

        foreach (seg_buf[i])
            seg_buf[i] = 8'h00;
        ctrl_byte = ledsr_pkg::CTRL_RESET;
        seq_kind  = ledsr_pkg::KIND_IDLE;
        seq_step  = 2'd0;
        bit_cnt   = '0;
        tx_num    = ledsr_pkg::TX_DATA;
        byte_cnt  = '0;
        shifter   = 8'h00;
        scl_lvl   = 1'b1;
        sda_lvl   = 1'b1;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: idle tick, no-op, buffer extremes, then a frame with
        // a request, writes and a no-op landing while it runs.
        add_item(ledsr_pkg::FUNC_TICK, 4'h0, 8'h00);
        add_item(FUNC_NOP, 4'hF, 8'hFF);
        add_item(ledsr_pkg::FUNC_WRITE, 4'h0, 8'hFF);
        add_item(ledsr_pkg::FUNC_WRITE, 4'hF, 8'h80);
        add_item(ledsr_pkg::FUNC_WRITE, 4'h7, 8'h01);
        add_item(ledsr_pkg::FUNC_REFRESH, 4'h0, 8'h00);
        repeat (4) add_item(ledsr_pkg::FUNC_TICK, 4'hF, 8'hFF);
        add_item(ledsr_pkg::FUNC_REFRESH, 4'h5, 8'h55);
        add_item(ledsr_pkg::FUNC_WRITE, 4'h1, 8'h5A);
        add_item(FUNC_NOP, 4'h0, 8'h00);
        add_item(ledsr_pkg::FUNC_WRITE, 4'hF, 8'h7F);
        repeat (6) add_item(ledsr_pkg::FUNC_TICK, 4'hA, 8'hA5);

        for (int phase = 0; phase < 4; phase++) begin
            if (phase > 0) begin
                // hold the sender until all results are back, then rewrite the display control byte
                wait_drained();
                if (phase == 1)
                    write_ctrl(8'd128);
                else if (phase == 2)
                    write_ctrl(8'd143);
                else
                    write_ctrl(8'($urandom_range(143, 128)));
            end
            send_idle_pct  = idle_tab[phase];
            recv_stall_pct = stall_tab[phase];
            repeat (PHASE_ITEMS) begin
                r       = $urandom_range(99);
                it.idx  = 4'($urandom);
                it.data = 8'($urandom);
                if (r < 85)
                    it.func = ledsr_pkg::FUNC_TICK;
                else if (r < 94)
                    it.func = ledsr_pkg::FUNC_WRITE;
                else if (r < 98)
                    it.func = ledsr_pkg::FUNC_REFRESH;
                else
                    it.func = FUNC_NOP;
                pend_q.push_back(it);
            end
        end

        wait_drained();
        repeat (8) @(posedge aclk);

        $display("Ran %0d items over four handshake idling phases with three control writes;",
                 items_sent);
        $display("%0d results compared, %0d refresh frames completed, %0d mismatches.",
                 results_seen, frames_seen, errors);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
